### design/pgse_pkg.sv
// ----------------------------------------------------------------------------
// pgse_pkg: shared constants and tables for the phong specular evaluator
// fixed-point widths, register indexes and the log2/exp2 lookup tables
// ----------------------------------------------------------------------------
package pgse_pkg;

    localparam int VEC_FRAC_BITS  = 14;
    localparam int LOG_TABLE_BITS = 10;
    localparam int TAB_N          = 1 << LOG_TABLE_BITS;
    localparam int TAB_AW         = LOG_TABLE_BITS + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_COEFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHININESS  = 3'd4;

    typedef logic [17:0] t_tab [0:TAB_N];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/N) in Q0.16 by repeated squaring
    function automatic t_tab build_log_tab();
        t_tab        tab;
        logic [63:0] x;
        logic [17:0] y;
        for (int i = 0; i < TAB_N; i++) begin
            x = 64'(TAB_N + i) << (30 - LOG_TABLE_BITS);
            y = 18'd0;
            for (int k = 1; k <= 16; k++) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    y = y | (18'd1 << (16 - k));
                end
            end
            tab[i] = y;
        end
        tab[TAB_N] = 18'd65536;
        return tab;
    endfunction

    // 2^(i/N) in Q1.16 from products of successive square roots of two
    function automatic t_tab build_exp_tab();
        t_tab        tab;
        logic [63:0] roots [0:16];
        logic [63:0] acc;
        logic [31:0] f;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
        for (int i = 0; i < TAB_N; i++) begin
            f   = 32'(i) << (16 - LOG_TABLE_BITS);
            acc = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (f[16-k]) acc = (acc * roots[k]) >> 30;
            end
            tab[i] = 18'((acc + (64'd1 << 13)) >> 14);
        end
        tab[TAB_N] = 18'd131072;
        return tab;
    endfunction

    localparam t_tab LOG_TAB = build_log_tab();
    localparam t_tab EXP_TAB = build_exp_tab();

endpackage

### design/phong_glossy_specular_eval_core.sv
// ----------------------------------------------------------------------------
// phong_glossy_specular_eval_core: phong glossy-specular reflectance
// reflects the incoming direction about the normal and raises r.wo to the
// shininess power through log2/exp2 tables, scaled by ks and the colour
// ----------------------------------------------------------------------------
// usage
//   input: one shading point (normal, incoming and outgoing directions, all
//   signed q1.14) is taken at each rising edge with i_start high and o_busy
//   low; o_busy is raised only while reset is held, so a new word may enter
//   every cycle
//   output: o_valid marks a single cycle in which o_refl_red/green/blue
//   (unsigned q0.16, saturated) and o_lobe_hit hold one result word; the
//   receiver cannot hold results off and none is needed
//   throughput: one word per cycle, set by the fully pipelined datapath; the
//   two table lookups are registered rom reads, the exp read sharing its stage with the colour times ks product
//   configuration: i_cfg_valid/o_cfg_ready write ks, the colour channels and the
//   q8.8 shininess by index; the user must make writes only while the pipe is
//   empty, which the block does not enforce; o_cfg_ready is low while reset is held
//   reset: synchronous, active low; clears the valid chain and loads the
//   register defaults (ks 0, colours full scale, shininess 1.0)
// ----------------------------------------------------------------------------
module phong_glossy_specular_eval_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [15:0]                 i_normal_x,
    input  logic signed [15:0]                 i_normal_y,
    input  logic signed [15:0]                 i_normal_z,
    input  logic signed [15:0]                 i_in_dir_x,
    input  logic signed [15:0]                 i_in_dir_y,
    input  logic signed [15:0]                 i_in_dir_z,
    input  logic signed [15:0]                 i_out_dir_x,
    input  logic signed [15:0]                 i_out_dir_y,
    input  logic signed [15:0]                 i_out_dir_z,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pgse_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    output logic                               o_valid,
    output logic [15:0]                        o_refl_red,
    output logic [15:0]                        o_refl_green,
    output logic [15:0]                        o_refl_blue,
    output logic                               o_lobe_hit
);
    import pgse_pkg::*;

    localparam int S2 = 2 * VEC_FRAC_BITS;
    localparam int LSH = 15 - LOG_TABLE_BITS;
    localparam int ESH = 16 - LOG_TABLE_BITS;

    // configuration registers
    logic [15:0] r_ks, r_cs_r, r_cs_g, r_cs_b, r_shin;

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks   <= 16'd0;
            r_cs_r <= 16'hFFFF;
            r_cs_g <= 16'hFFFF;
            r_cs_b <= 16'hFFFF;
            r_shin <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPEC_COEFF: r_ks   <= i_cfg_data;
                CFG_SPEC_RED:   r_cs_r <= i_cfg_data;
                CFG_SPEC_GREEN: r_cs_g <= i_cfg_data;
                CFG_SPEC_BLUE:  r_cs_b <= i_cfg_data;
                CFG_SHININESS:  r_shin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain, one bit per stage
    logic [13:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[12:0], i_start};
    end

    // ---- stage 1: n * wi products
    logic signed [15:0] r1_n [3], r1_wi [3], r1_wo [3];
    logic signed [31:0] r1_p [3];
    always_ff @(posedge i_clk) begin
        r1_n[0] <= i_normal_x;  r1_n[1] <= i_normal_y;  r1_n[2] <= i_normal_z;
        r1_wi[0] <= i_in_dir_x; r1_wi[1] <= i_in_dir_y; r1_wi[2] <= i_in_dir_z;
        r1_wo[0] <= i_out_dir_x; r1_wo[1] <= i_out_dir_y; r1_wo[2] <= i_out_dir_z;
        r1_p[0] <= i_normal_x * i_in_dir_x;
        r1_p[1] <= i_normal_y * i_in_dir_y;
        r1_p[2] <= i_normal_z * i_in_dir_z;
    end

    // ---- stage 2: d = n.wi
    logic signed [15:0] r2_n [3], r2_wi [3], r2_wo [3];
    logic signed [32:0] r2_d;
    always_ff @(posedge i_clk) begin
        r2_n <= r1_n; r2_wi <= r1_wi; r2_wo <= r1_wo;
        r2_d <= 33'(r1_p[0]) + 33'(r1_p[1]) + 33'(r1_p[2]);
    end

    // ---- stage 3: d * n split in two partial products
    logic signed [15:0] r3_wi [3], r3_wo [3];
    logic signed [32:0] r3_ph [3], r3_pl [3];
    logic signed [16:0] n3_dh, n3_dl;
    always_comb begin
        n3_dh = r2_d[32:16];
        n3_dl = $signed({1'b0, r2_d[15:0]});
    end
    always_ff @(posedge i_clk) begin
        r3_wi <= r2_wi; r3_wo <= r2_wo;
        for (int i = 0; i < 3; i++) begin
            r3_ph[i] <= n3_dh * r2_n[i];
            r3_pl[i] <= n3_dl * r2_n[i];
        end
    end

    // ---- stage 4: r = round(2 d n) - wi
    logic signed [15:0] r4_wo [3];
    logic signed [21:0] r4_r [3];
    logic signed [50:0] n4_w [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_w[i] = ((51'(r3_ph[i]) <<< 16) + 51'(r3_pl[i])) * 51'sd2
                      + (51'sd1 <<< (S2 - 1));
        end
    end
    always_ff @(posedge i_clk) begin
        r4_wo <= r3_wo;
        for (int i = 0; i < 3; i++)
            r4_r[i] <= 22'(n4_w[i] >>> S2) - 22'(r3_wi[i]);
    end

    // ---- stage 5: r * wo products
    logic signed [37:0] r5_p [3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) r5_p[i] <= r4_r[i] * r4_wo[i];
    end

    // ---- stage 6: s = r.wo
    logic signed [39:0] r6_s;
    always_ff @(posedge i_clk) begin
        r6_s <= 40'(r5_p[0]) + 40'(r5_p[1]) + 40'(r5_p[2]);
    end

    // ---- stage 7: clamp to q0.16, leading one, log table index
    logic        n7_hit, n7_big;
    logic [15:0] n7_c, n7_m;
    logic [3:0]  n7_e;
    logic        r7_hit, r7_unity, r7_zero;
    logic [3:0]  r7_e;
    logic [LOG_TABLE_BITS-1:0] r7_idx;
    logic [LSH-1:0]            r7_res;
    always_comb begin
        n7_hit = !r6_s[39] && (r6_s != 40'sd0);
        n7_big = (r6_s[39:S2] != '0);
        n7_c   = r6_s[S2-1:S2-16];
        n7_e   = 4'd0;
        for (int b = 0; b < 16; b++) begin
            if (n7_c[b]) n7_e = 4'(b);
        end
        n7_m = (n7_c << (4'd15 - n7_e)) & 16'h7FFF;
    end
    always_ff @(posedge i_clk) begin
        r7_hit   <= n7_hit;
        r7_unity <= (r_shin == 16'd0) || n7_big;
        r7_zero  <= (n7_c == 16'd0);
        r7_e     <= n7_e;
        r7_idx   <= n7_m[14:LSH];
        r7_res   <= n7_m[LSH-1:0];
    end

    // ---- stage 8: log rom read
    logic        r8_hit, r8_unity, r8_zero;
    logic [3:0]  r8_e;
    logic [LSH-1:0] r8_res;
    logic [17:0] r8_llo, r8_lhi;
    always_ff @(posedge i_clk) begin
        r8_hit <= r7_hit; r8_unity <= r7_unity; r8_zero <= r7_zero;
        r8_e <= r7_e; r8_res <= r7_res;
        r8_llo <= LOG_TAB[{1'b0, r7_idx}];
        r8_lhi <= LOG_TAB[TAB_AW'({1'b0, r7_idx}) + TAB_AW'(1)];
    end

    // ---- stage 9: interpolate, negative log magnitude
    logic [17:0] n9_flog;
    logic [22:0] n9_dp;
    logic        r9_hit, r9_unity, r9_zero;
    logic [20:0] r9_lmag;
    always_comb begin
        n9_dp   = 23'(r8_lhi - r8_llo) * 23'(r8_res);
        n9_flog = r8_llo + 18'(n9_dp >> LSH);
    end
    always_ff @(posedge i_clk) begin
        r9_hit <= r8_hit; r9_unity <= r8_unity; r9_zero <= r8_zero;
        r9_lmag <= (21'(5'd16 - {1'b0, r8_e}) << 16) - 21'(n9_flog);
    end

    // ---- stage 10: scale by the exponent
    logic [36:0] n10_q;
    logic        r10_hit, r10_unity, r10_zero;
    logic [28:0] r10_q;
    always_comb n10_q = 37'(r9_lmag) * 37'(r_shin) + 37'd128;
    always_ff @(posedge i_clk) begin
        r10_hit <= r9_hit; r10_unity <= r9_unity; r10_zero <= r9_zero;
        r10_q <= n10_q[36:8];
    end

    // ---- stage 11: split q, exp table index
    logic [12:0] n11_ip;
    logic [15:0] n11_fp, n11_g;
    logic        r11_hit, r11_unity, r11_zero, r11_fpz;
    logic [16:0] r11_direct;
    logic [4:0]  r11_sh;
    logic [LOG_TABLE_BITS-1:0] r11_idx;
    logic [ESH-1:0]            r11_res;
    always_comb begin
        n11_ip = r10_q[28:16];
        n11_fp = r10_q[15:0];
        n11_g  = 16'(17'd65536 - 17'(n11_fp));
    end
    always_ff @(posedge i_clk) begin
        r11_hit <= r10_hit; r11_unity <= r10_unity;
        r11_fpz <= (n11_fp == 16'd0);
        if (n11_fp == 16'd0) begin
            r11_zero   <= r10_zero;
            r11_direct <= (n11_ip >= 13'd20) ? 17'd0 : (17'd65536 >> n11_ip[4:0]);
        end else begin
            r11_zero   <= r10_zero || (n11_ip >= 13'd19);
            r11_direct <= 17'd0;
        end
        r11_sh  <= 5'(n11_ip[4:0] + 5'd1);
        r11_idx <= n11_g[15:ESH];
        r11_res <= n11_g[ESH-1:0];
    end

    // ---- stage 12: exp rom read, colour times ks
    logic        r12_hit, r12_unity, r12_zero, r12_fpz;
    logic [16:0] r12_direct;
    logic [4:0]  r12_sh;
    logic [ESH-1:0] r12_res;
    logic [17:0] r12_elo, r12_ehi;
    logic [15:0] r12_t [3];
    logic [31:0] n12_t [3];
    always_comb begin
        n12_t[0] = r_ks * r_cs_r;
        n12_t[1] = r_ks * r_cs_g;
        n12_t[2] = r_ks * r_cs_b;
    end
    always_ff @(posedge i_clk) begin
        r12_hit <= r11_hit; r12_unity <= r11_unity; r12_zero <= r11_zero;
        r12_fpz <= r11_fpz; r12_direct <= r11_direct; r12_sh <= r11_sh;
        r12_res <= r11_res;
        r12_elo <= EXP_TAB[{1'b0, r11_idx}];
        r12_ehi <= EXP_TAB[TAB_AW'({1'b0, r11_idx}) + TAB_AW'(1)];
        for (int i = 0; i < 3; i++) r12_t[i] <= n12_t[i][31:16];
    end

    // ---- stage 13: interpolate exp, pick the power
    logic [23:0] n13_dp;
    logic [17:0] n13_ev;
    logic [16:0] n13_pw;
    logic        r13_hit;
    logic [16:0] r13_pw;
    logic [15:0] r13_t [3];
    always_comb begin
        n13_dp = 24'(r12_ehi - r12_elo) * 24'(r12_res);
        n13_ev = r12_elo + 18'(n13_dp >> ESH);
        if (r12_unity)     n13_pw = 17'd65536;
        else if (r12_zero) n13_pw = 17'd0;
        else if (r12_fpz)  n13_pw = r12_direct;
        else               n13_pw = 17'(n13_ev >> r12_sh);
    end
    always_ff @(posedge i_clk) begin
        r13_hit <= r12_hit;
        r13_pw  <= n13_pw;
        r13_t   <= r12_t;
    end

    // ---- stage 14: shade and saturate
    logic [32:0] n14_v [3];
    logic [15:0] n14_o [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n14_v[i] = 33'(r13_t[i]) * 33'(r13_pw);
            if (!r13_hit)                   n14_o[i] = 16'd0;
            else if (n14_v[i][32:32] != '0) n14_o[i] = 16'hFFFF;
            else                            n14_o[i] = n14_v[i][31:16];
        end
    end
    always_ff @(posedge i_clk) begin
        o_refl_red   <= n14_o[0];
        o_refl_green <= n14_o[1];
        o_refl_blue  <= n14_o[2];
        o_lobe_hit   <= r13_hit;
    end

    assign o_valid = r_vld[13];

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for phong_glossy_specular_eval_core
// drives shading points through the start/busy port, predicts each result
// word with an independent fixed-point phong model and checks every strobe
// ----------------------------------------------------------------------------
module tb_top;

    import pgse_pkg::*;

    localparam int FRAC     = 14;
    localparam int LTB      = 10;
    localparam int NTAB     = 1 << LTB;
    localparam int ONE      = 1 << FRAC;
    localparam int DRAIN    = 20;           // cycles past the last result word
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SHININESS + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_SHININESS + 3'd3;

    typedef struct {
        shortint n  [3];
        shortint wi [3];
        shortint wo [3];
    } t_shade_pt;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        hit;
    } t_refl_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic signed [15:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [15:0] i_in_dir_x = '0, i_in_dir_y = '0, i_in_dir_z = '0;
    logic signed [15:0] i_out_dir_x = '0, i_out_dir_y = '0, i_out_dir_z = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        o_valid;
    logic [15:0] o_refl_red, o_refl_green, o_refl_blue;
    logic        o_lobe_hit;

    // our own copy of the register file
    logic [15:0] ks_reg, red_reg, green_reg, blue_reg, shin_reg;

    // log2 / exp2 tables rebuilt here from first principles
    int unsigned log2_lut [0:NTAB];
    int unsigned exp2_lut [0:NTAB];

    t_refl_word refl_expect_q [$];
    int         mismatches = 0;
    int         words_checked = 0;
    int         points_sent = 0;
    int         lobe_hits = 0;
    int         cfg_writes = 0;
    bit         idle_on = 1'b1;

    always #5 i_clk = ~i_clk;

    phong_glossy_specular_eval_core dut (.*);

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned v_in);
        longint unsigned v, res, b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic fill_luts();
        longint unsigned roots [17];
        longint unsigned acc, x;
        int unsigned     f, y;
        roots[0] = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
        for (int i = 0; i < NTAB; i++) begin
            f = i << (16 - LTB);
            acc = 64'd1 << 30;
            x = longint'(NTAB + i) << (30 - LTB);
            y = 0;
            for (int k = 1; k <= 16; k++) begin
                if ((f >> (16 - k)) & 1) acc = (acc * roots[k]) >> 30;
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x = x >> 1;
                    y = y | (1 << (16 - k));
                end
            end
            exp2_lut[i] = int'((acc + (64'd1 << 13)) >> 14);
            log2_lut[i] = y;
        end
        exp2_lut[NTAB] = 131072;
        log2_lut[NTAB] = 65536;
    endtask

    // c^shininess with c in q0.16, result q1.16
    function automatic int unsigned cos_power(int unsigned c);
        int unsigned e, m, idx, rem, flog, lmag, q, ip, fp, g, ev;
        e = 15;
        if (shin_reg == 0 || c >= 65536) return 65536;
        if (c == 0) return 0;
        while (((c >> e) & 1) == 0) e--;
        m = (c << (15 - e)) & 32'h7fff;
        idx = m >> (15 - LTB);
        rem = m & ((1 << (15 - LTB)) - 1);
        flog = log2_lut[idx] + (((log2_lut[idx+1] - log2_lut[idx]) * rem) >> (15 - LTB));
        lmag = (16 - e) * 65536 - flog;
        q = int'((longint'(lmag) * shin_reg + 128) >> 8);
        ip = q >> 16;
        fp = q & 32'hffff;
        if (fp == 0) return (ip >= 20) ? 0 : (65536 >> ip);
        if (ip + 1 >= 20) return 0;
        g = 65536 - fp;
        idx = g >> (16 - LTB);
        rem = g & ((1 << (16 - LTB)) - 1);
        ev = exp2_lut[idx] + (((exp2_lut[idx+1] - exp2_lut[idx]) * rem) >> (16 - LTB));
        return ev >> (ip + 1);
    endfunction

    function automatic logic [15:0] tint(logic [15:0] cs, int unsigned pw);
        longint unsigned t, v;
        t = (longint'(ks_reg) * cs) >> 16;
        v = (t * pw) >> 16;
        return (v > 65535) ? 16'hffff : v[15:0];
    endfunction

    // mirror of wi about n, q1.14 with round half up
    function automatic longint mirror_comp(t_shade_pt p, int k);
        longint d;
        d = 0;
        for (int i = 0; i < 3; i++) d += longint'(p.n[i]) * p.wi[i];
        return ((2 * d * p.n[k] + (64'sd1 << (2*FRAC - 1))) >>> (2*FRAC)) - p.wi[k];
    endfunction

    function automatic t_refl_word phong_predict(t_shade_pt p);
        t_refl_word      w;
        longint          s;
        longint unsigned cw;
        int unsigned     pw;
        s = 0;
        for (int k = 0; k < 3; k++) s += mirror_comp(p, k) * p.wo[k];
        w = '{16'd0, 16'd0, 16'd0, 1'b0};
        if (s > 0) begin
            cw = longint'(s) >> (2*FRAC - 16);
            pw = cos_power((cw > 65536) ? 65536 : int'(cw));
            w = '{tint(red_reg, pw), tint(green_reg, pw), tint(blue_reg, pw), 1'b1};
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_point(t_shade_pt p);
        i_cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(99) < 20) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_normal_x  <= p.n[0];  i_normal_y  <= p.n[1];  i_normal_z  <= p.n[2];
        i_in_dir_x  <= p.wi[0]; i_in_dir_y  <= p.wi[1]; i_in_dir_z  <= p.wi[2];
        i_out_dir_x <= p.wo[0]; i_out_dir_y <= p.wo[1]; i_out_dir_z <= p.wo[2];
        do @(posedge i_clk); while (o_busy);
        // accepted at this edge: config is stable, so predict now
        refl_expect_q.push_back(phong_predict(p));
        points_sent++;
    endtask

    task automatic pipe_drain();
        i_start     <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (refl_expect_q.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // valid is left high on return; the next send or drain lowers it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        if (idle_on && $urandom_range(99) < 20) begin
            i_cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SPEC_COEFF: ks_reg    = val;
            CFG_SPEC_RED:   red_reg   = val;
            CFG_SPEC_GREEN: green_reg = val;
            CFG_SPEC_BLUE:  blue_reg  = val;
            CFG_SHININESS:  shin_reg  = val;
            default: ;      // spare indexes are dropped by the block
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(logic [15:0] ks, logic [15:0] r, logic [15:0] g,
                             logic [15:0] b, logic [15:0] sh);
        pipe_drain();
        write_reg(CFG_SPEC_COEFF, ks);
        write_reg(CFG_SPEC_RED, r);
        write_reg(CFG_SPEC_GREEN, g);
        write_reg(CFG_SPEC_BLUE, b);
        write_reg(CFG_SHININESS, sh);
    endtask

    function automatic t_shade_pt mk_pt(int nx, int ny, int nz, int ix, int iy, int iz,
                                        int ox, int oy, int oz);
        t_shade_pt p;
        p.n  = '{shortint'(nx), shortint'(ny), shortint'(nz)};
        p.wi = '{shortint'(ix), shortint'(iy), shortint'(iz)};
        p.wo = '{shortint'(ox), shortint'(oy), shortint'(oz)};
        return p;
    endfunction

    function automatic shortint rnd_q14();
        return shortint'($urandom_range(2*ONE) - ONE);
    endfunction

    function automatic shortint rnd_raw();
        return shortint'($urandom_range(16'hffff));
    endfunction

    // random point: mostly viewer near the mirror direction, some noise
    function automatic t_shade_pt rnd_point();
        t_shade_pt p;
        longint    rc;
        int        sel;
        sel = $urandom_range(99);
        for (int k = 0; k < 3; k++) begin
            p.n[k]  = (sel < 10) ? rnd_raw() : rnd_q14();
            p.wi[k] = (sel < 10) ? rnd_raw() : rnd_q14();
            p.wo[k] = (sel < 10) ? rnd_raw() : rnd_q14();
        end
        if (sel >= 40) begin
            // view close to the reflected ray, jittered to sweep the lobe
            for (int k = 0; k < 3; k++) begin
                rc = mirror_comp(p, k) + $signed($urandom_range(2000)) - 1000;
                if (rc > 32767) rc = 32767;
                if (rc < -32768) rc = -32768;
                p.wo[k] = shortint'(rc);
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // ks resets to zero: hits report the flag with black colour
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, -ONE));
        pipe_drain();
        write_reg(CFG_SPEC_COEFF, 16'hffff);
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
        send_point(mk_pt(0, 0, ONE, 11585, 0, 11585, -11585, 0, 11585));
    endtask

    task automatic test_directed_cases();
        write_all(16'hffff, 16'hffff, 16'h8000, 16'h0001, 16'h0800);
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));          // head-on
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, -ONE));         // lobe missed
        send_point(mk_pt(0, 0, ONE, 0, 0, 1, 0, 0, 100));            // tiny dot
        send_point(mk_pt(0, 0, ONE, 0, 0, 1, 0, 0, ONE));            // small dot
        send_point(mk_pt(0, 0, ONE, 11585, 0, 11585, -11585, 0, 11585));
        send_point(mk_pt(0, 0, ONE, 11585, 0, 11585, -11000, 3000, 11000));
        send_point(mk_pt(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE)); // dot above one
        send_point(mk_pt(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE));
        send_point(mk_pt(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768));                    // out of range
        send_point(mk_pt(32767, -32768, 32767, -32768, 32767, -32768,
                         32767, 32767, -32768));
        send_point(mk_pt(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_point(mk_pt(0, 0, 0, 0, 0, 0, 0, 0, 0));                // zero vectors
        send_point(mk_pt(ONE, 0, 0, 0, ONE, 0, 0, ONE, 0));          // grazing
        // zero exponent: full colour on any hit
        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000);
        send_point(mk_pt(0, 0, ONE, 0, 0, 1, 0, 0, 100));
        send_point(mk_pt(0, 0, ONE, 11585, 0, 11585, -11000, 3000, 11000));
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, -ONE));
        // largest exponent: an exact hit, then a view just off the mirror ray
        write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 10, 16380));
        // spare indexes must leave the register file alone
        pipe_drain();
        write_reg(CFG_SPARE_LO, 16'h0000);
        write_reg(CFG_SPARE_HI, 16'h1234);
        send_point(mk_pt(0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
    endtask

    task automatic test_random_phases();
        logic [15:0] sh;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: sh = 16'h0100;
                1: sh = 16'h0000;
                2: sh = 16'hffff;
                3: sh = 16'h0001;
                default: sh = 16'($urandom_range(16'h0800));
            endcase
            if (ph == 4) write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, sh);
            else write_all(16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)),
                           16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)),
                           sh);
            // one phase runs back to back with no gaps at all
            idle_on = (ph != 5);
            repeat (150) send_point(rnd_point());
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_refl_word exp_w;
        if (i_rst_n && o_valid) begin
            if (refl_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                exp_w = refl_expect_q.pop_front();
                words_checked++;
                if (exp_w.hit) lobe_hits++;
                if (o_refl_red !== exp_w.red || o_refl_green !== exp_w.green ||
                    o_refl_blue !== exp_w.blue || o_lobe_hit !== exp_w.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp r%h g%h b%h hit%b got r%h g%h b%h hit%b",
                                 words_checked, exp_w.red, exp_w.green, exp_w.blue,
                                 exp_w.hit, o_refl_red, o_refl_green, o_refl_blue,
                                 o_lobe_hit);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        ks_reg = 16'd0; red_reg = 16'hffff; green_reg = 16'hffff;
        blue_reg = 16'hffff; shin_reg = 16'd256;
        fill_luts();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_cases();
        test_random_phases();
        pipe_drain();
        $display("covered %0d points, %0d result words (%0d lobe hits), %0d register writes",
                 points_sent, words_checked, lobe_hits, cfg_writes);
        if (refl_expect_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("timeout");
        $display("tb: failure");
        $finish;
    end

endmodule

### phong_glossy_specular_eval_core.f
design/pgse_pkg.sv
design/phong_glossy_specular_eval_core.sv
tb/tb_top.sv
